// ----- sv/q2e_pkg.sv -----
// shared constants and the arctangent table for the quaternion to euler converter
`default_nettype none
package q2e_pkg;
    localparam int Q30_FRAC = 30;
    localparam int CW = 40;
    localparam logic signed [CW-1:0] Q30_ONE_C = 40'sd1073741824;
    localparam logic signed [CW-1:0] Q30_PI_C = 40'sd3373259426;
    localparam logic signed [CW-1:0] Q30_HALF_PI_C = 40'sd1686629713;

    function automatic logic signed [CW-1:0] atan_entry(input int i);
        logic signed [CW-1:0] t;
        begin
            case (i)
                0: t = 40'sd843314856;
                1: t = 40'sd497837829;
                2: t = 40'sd263043836;
                3: t = 40'sd133525158;
                4: t = 40'sd67021686;
                5: t = 40'sd33543515;
                6: t = 40'sd16775850;
                7: t = 40'sd8388437;
                8: t = 40'sd4194282;
                9: t = 40'sd2097149;
                10: t = 40'sd1048575;
                11: t = 40'sd524287;
                12: t = 40'sd262143;
                13: t = 40'sd131071;
                14: t = 40'sd65535;
                15: t = 40'sd32767;
                16: t = 40'sd16383;
                17: t = 40'sd8191;
                18: t = 40'sd4095;
                19: t = 40'sd2047;
                20: t = 40'sd1023;
                21: t = 40'sd511;
                22: t = 40'sd255;
                23: t = 40'sd127;
                24: t = 40'sd63;
                25: t = 40'sd31;
                26: t = 40'sd15;
                27: t = 40'sd7;
                28: t = 40'sd3;
                29: t = 40'sd1;
                default: t = '0;
            endcase
            return t;
        end
    endfunction
endpackage
`default_nettype wire

// ----- sv/q2e_cordic.sv -----
// pipelined vectoring cordic, a pre-rotation stage then one iteration per register stage
`default_nettype none
module q2e_cordic #(
    parameter int STAGES = 16
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic signed [q2e_pkg::CW-1:0] y_in,
    input  wire logic signed [q2e_pkg::CW-1:0] x_in,
    output logic signed [q2e_pkg::CW-1:0]      angle
);
    import q2e_pkg::*;

    localparam int N = (STAGES > 32) ? 32 : STAGES;

    logic signed [CW-1:0] x_reg [N+1];
    logic signed [CW-1:0] y_reg [N+1];
    logic signed [CW-1:0] z_reg [N+1];
    logic                 zero_reg [N+1];

    // pre-rotation by pi for a negative x operand
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg[0] <= (x_in == '0) && (y_in == '0);
            if (x_in < 0)
            begin
                x_reg[0] <= -x_in;
                y_reg[0] <= -y_in;
                z_reg[0] <= (y_in >= 0) ? Q30_PI_C : -Q30_PI_C;
            end
            else
            begin
                x_reg[0] <= x_in;
                y_reg[0] <= y_in;
                z_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_it
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                zero_reg[i+1] <= zero_reg[i];
                if (y_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_entry(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_entry(i);
                end
            end
        end
    end

    assign angle = zero_reg[N] ? '0 : z_reg[N];
endmodule
`default_nettype wire

// ----- sv/quaternion_to_euler.sv -----
// quaternion to zyx euler angle converter, top level
// input channel: in_valid/in_stall with quat_w..quat_z, signed q1.(QUAT_WIDTH-2)
// output channel: out_valid/out_stall with roll and yaw, signed q2.(ANGLE_WIDTH-3),
//   pitch q1.(ANGLE_WIDTH-3); one beat in gives exactly one beat out, in order
// throughput: one beat per cycle while the pipeline is not frozen by an output stall
// pipeline: 2 product and operand stages, 2 stages for the square of the
//   arcsine argument, 31 square root stages (one root bit each), 1 pre-rotation
//   stage, CORDIC_STAGES (at most 32) iteration stages and 1 output rounding stage
// the square root sets the depth at the default: it resolves one root bit per stage
// reset clears all valid bits; payload registers are not reset
// a stall on the output freezes the whole pipeline; in_stall follows out_stall
//   only while the output register is full
`default_nettype none
module quaternion_to_euler #(
    parameter int QUAT_WIDTH = 16,
    parameter int ANGLE_WIDTH = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic signed [QUAT_WIDTH-1:0]  quat_w,
    input  wire logic signed [QUAT_WIDTH-1:0]  quat_x,
    input  wire logic signed [QUAT_WIDTH-1:0]  quat_y,
    input  wire logic signed [QUAT_WIDTH-1:0]  quat_z,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic signed [ANGLE_WIDTH-1:0]      roll_angle,
    output logic signed [ANGLE_WIDTH-2:0]      pitch_angle,
    output logic signed [ANGLE_WIDTH-1:0]      yaw_angle
);
    import q2e_pkg::*;

    localparam int NC = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
    localparam int PW = 2 * QUAT_WIDTH;
    localparam int FB = 2 * (QUAT_WIDTH - 2);
    localparam int SQ = 32;
    localparam int LAT = 4 + (SQ - 1) + 1 + NC;
    localparam int SH = 33 - ANGLE_WIDTH;
    localparam int WW = 64;

    logic adv;
    logic [LAT-1:0] vld_reg;
    assign adv = !out_valid || !out_stall;
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            out_valid <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
            out_valid <= vld_reg[LAT-1];
        end
    end

    // stage 1: nine products in q.30
    function automatic logic signed [CW-1:0] to_q30(input logic signed [PW-1:0] p);
        logic signed [WW-1:0] e;
        begin
            e = WW'(p);
            if (FB > Q30_FRAC)
                e = e >>> (FB - Q30_FRAC);
            else
                e = e <<< (Q30_FRAC - FB);
            return e[CW-1:0];
        end
    endfunction

    logic signed [CW-1:0] wx_reg, yz_reg, wz_reg, xy_reg, wy_reg, zx_reg;
    logic signed [CW-1:0] xx_reg, yy_reg, zz_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            wx_reg <= to_q30(quat_w * quat_x);
            yz_reg <= to_q30(quat_y * quat_z);
            wz_reg <= to_q30(quat_w * quat_z);
            xy_reg <= to_q30(quat_x * quat_y);
            wy_reg <= to_q30(quat_w * quat_y);
            zx_reg <= to_q30(quat_z * quat_x);
            xx_reg <= to_q30(quat_x * quat_x);
            yy_reg <= to_q30(quat_y * quat_y);
            zz_reg <= to_q30(quat_z * quat_z);
        end
    end

    // stage 2: atan2 operands and the clamped arcsine argument
    logic signed [CW-1:0] rn_reg, rd_reg, yn_reg, yd_reg, a_reg;
    logic signed [CW-1:0] a_next;
    always_comb
    begin
        a_next = (wy_reg - zx_reg) <<< 1;
        if (a_next > Q30_ONE_C)
            a_next = Q30_ONE_C;
        if (a_next < -Q30_ONE_C)
            a_next = -Q30_ONE_C;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rn_reg <= (wx_reg + yz_reg) <<< 1;
            rd_reg <= Q30_ONE_C - ((xx_reg + yy_reg) <<< 1);
            yn_reg <= (wz_reg + xy_reg) <<< 1;
            yd_reg <= Q30_ONE_C - ((yy_reg + zz_reg) <<< 1);
            a_reg <= a_next;
        end
    end

    // square root of 2^60 - a*a, one root bit per stage; a*a split so no wide multiply
    logic [31:0] aa_mag;
    assign aa_mag = a_reg[CW-1] ? 32'(-a_reg) : 32'(a_reg);

    logic [61:0] rem_reg [SQ];
    logic [30:0] res_reg [SQ];
    logic [CW-1:0] rn_d [SQ+1], rd_d [SQ+1], yn_d [SQ+1], yd_d [SQ+1], a_d [SQ+1];

    // stage 0 of the chain computes the square as partial products
    logic [31:0] sq_lo_reg, sq_hi_reg, sq_mid_reg;
    logic [15:0] ah, al;
    assign ah = aa_mag[31:16];
    assign al = aa_mag[15:0];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_hi_reg <= ah * ah;
            sq_mid_reg <= ah * al;
            sq_lo_reg <= al * al;
            rn_d[0] <= rn_reg;
            rd_d[0] <= rd_reg;
            yn_d[0] <= yn_reg;
            yd_d[0] <= yd_reg;
            a_d[0] <= a_reg;
        end
    end

    logic [63:0] aa_sum;
    logic [63:0] rad;
    assign aa_sum = {sq_hi_reg, 32'd0} + {15'd0, sq_mid_reg, 17'd0} + {32'd0, sq_lo_reg};
    assign rad = 64'h1000_0000_0000_0000 - aa_sum;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0] <= rad[61:0];
            res_reg[0] <= '0;
            rn_d[1] <= rn_d[0];
            rd_d[1] <= rd_d[0];
            yn_d[1] <= yn_d[0];
            yd_d[1] <= yd_d[0];
            a_d[1] <= a_d[0];
        end
    end

    for (genvar k = 0; k < SQ - 1; k++) begin : g_sq
        localparam int B = 30 - k;
        logic [62:0] trial;
        logic [61:0] cand;
        assign cand = 62'(res_reg[k]) << (B + 1);
        assign trial = 63'(cand) + (63'd1 << (2 * B));
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (63'(rem_reg[k]) >= trial)
                begin
                    rem_reg[k+1] <= rem_reg[k] - trial[61:0];
                    res_reg[k+1] <= res_reg[k] | (31'd1 << B);
                end
                else
                begin
                    rem_reg[k+1] <= rem_reg[k];
                    res_reg[k+1] <= res_reg[k];
                end
                rn_d[k+2] <= rn_d[k+1];
                rd_d[k+2] <= rd_d[k+1];
                yn_d[k+2] <= yn_d[k+1];
                yd_d[k+2] <= yd_d[k+1];
                a_d[k+2] <= a_d[k+1];
            end
        end
    end

    logic signed [CW-1:0] root;
    assign root = CW'({1'b0, res_reg[SQ-1]});

    logic signed [CW-1:0] roll_z, pitch_z, yaw_z;
    q2e_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
        .clk(clk), .en(adv), .y_in(rn_d[SQ]), .x_in(rd_d[SQ]), .angle(roll_z));
    q2e_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
        .clk(clk), .en(adv), .y_in(a_d[SQ]), .x_in(root), .angle(pitch_z));
    q2e_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
        .clk(clk), .en(adv), .y_in(yn_d[SQ]), .x_in(yd_d[SQ]), .angle(yaw_z));

    function automatic logic signed [CW-1:0] clamp_round(
        input logic signed [CW-1:0] z, input logic signed [CW-1:0] lim);
        logic signed [CW-1:0] c;
        begin
            c = z;
            if (c > lim)
                c = lim;
            if (c < -lim)
                c = -lim;
            return (c + (CW'(1) <<< (SH - 1))) >>> SH;
        end
    endfunction

    logic signed [CW-1:0] roll_r, pitch_r, yaw_r;
    assign roll_r = clamp_round(roll_z, Q30_PI_C);
    assign pitch_r = clamp_round(pitch_z, Q30_HALF_PI_C);
    assign yaw_r = clamp_round(yaw_z, Q30_PI_C);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            roll_angle <= roll_r[ANGLE_WIDTH-1:0];
            pitch_angle <= pitch_r[ANGLE_WIDTH-2:0];
            yaw_angle <= yaw_r[ANGLE_WIDTH-1:0];
        end
    end

    logic unused_tail;
    assign unused_tail = ^rem_reg[SQ-1];
endmodule
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// testbench for the quaternion to euler converter: random and directed beats, scoreboard check
`timescale 1ns / 1ps
`default_nettype none

class euler_scoreboard;
    logic signed [15:0] roll_q[$];
    logic signed [14:0] pitch_q[$];
    logic signed [15:0] yaw_q[$];
    int errors;
    int checked;

    function new();
        errors = 0;
        checked = 0;
    endfunction

    static function longint asr(longint v, int s);
        return v >>> s;
    endfunction

    static function longint prod_q30(longint a, longint b);
        return (a * b) <<< 2;
    endfunction

    static function longint vector_angle(longint y, longint x);
        longint z;
        longint xs;
        longint ys;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0)
        begin
            z = (y >= 0) ? 64'sd3373259426 : -64'sd3373259426;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < 16; i++)
        begin
            xs = asr(x, i);
            ys = asr(y, i);
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z += longint'(q2e_pkg::atan_entry(i));
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z -= longint'(q2e_pkg::atan_entry(i));
            end
        end
        return z;
    endfunction

    static function longint root_floor(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return longint'(res);
    endfunction

    static function longint round_angle(longint z, longint lim);
        if (z > lim)
            z = lim;
        if (z < -lim)
            z = -lim;
        return asr(z + (64'sd1 << 16), 17);
    endfunction

    function void note_quat(logic signed [15:0] qw, logic signed [15:0] qx,
                            logic signed [15:0] qy, logic signed [15:0] qz);
        longint w, x, y, z, xx, yy, zz, rn, rd, yn, yd, a, s, one;
        w = qw;
        x = qx;
        y = qy;
        z = qz;
        one = 64'sd1 << 30;
        xx = prod_q30(x, x);
        yy = prod_q30(y, y);
        zz = prod_q30(z, z);
        rn = 2 * (prod_q30(w, x) + prod_q30(y, z));
        rd = one - 2 * (xx + yy);
        yn = 2 * (prod_q30(w, z) + prod_q30(x, y));
        yd = one - 2 * (yy + zz);
        a = 2 * (prod_q30(w, y) - prod_q30(z, x));
        if (a > one)
            a = one;
        if (a < -one)
            a = -one;
        s = root_floor((64'd1 << 60) - longint'(a * a));
        roll_q.push_back(16'(round_angle(vector_angle(rn, rd), 64'sd3373259426)));
        pitch_q.push_back(15'(round_angle(vector_angle(a, s), 64'sd1686629713)));
        yaw_q.push_back(16'(round_angle(vector_angle(yn, yd), 64'sd3373259426)));
    endfunction

    function void check_angles(logic signed [15:0] r, logic signed [14:0] p,
                               logic signed [15:0] yw);
        logic signed [15:0] er;
        logic signed [14:0] ep;
        logic signed [15:0] ey;
        if (roll_q.size() == 0)
        begin
            $display("%0t: result beat with nothing expected r=%0d p=%0d y=%0d",
                     $time, r, p, yw);
            errors++;
            return;
        end
        er = roll_q.pop_front();
        ep = pitch_q.pop_front();
        ey = yaw_q.pop_front();
        checked++;
        if (r !== er)
        begin
            $display("%0t: roll expected %0d actual %0d", $time, er, r);
            errors++;
        end
        if (p !== ep)
        begin
            $display("%0t: pitch expected %0d actual %0d", $time, ep, p);
            errors++;
        end
        if (yw !== ey)
        begin
            $display("%0t: yaw expected %0d actual %0d", $time, ey, yw);
            errors++;
        end
    endfunction

    function int pending();
        return roll_q.size();
    endfunction
endclass

module tb_top;
    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic signed [15:0] quat_w, quat_x, quat_y, quat_z;
    logic out_valid;
    logic out_stall;
    logic signed [15:0] roll_angle;
    logic signed [14:0] pitch_angle;
    logic signed [15:0] yaw_angle;

    euler_scoreboard angle_board;
    int cycle_count = 0;
    bit sending_done;
    int quats_sent;

    quaternion_to_euler uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .roll_angle(roll_angle), .pitch_angle(pitch_angle), .yaw_angle(yaw_angle)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // beat is taken on the rising edge, next one offered on the falling edge
    task automatic send_quat(logic signed [15:0] w, logic signed [15:0] x,
                             logic signed [15:0] y, logic signed [15:0] z);
        in_valid <= 1'b1;
        quat_w <= w;
        quat_x <= x;
        quat_y <= y;
        quat_z <= z;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        angle_board.note_quat(w, x, y, z);
        quats_sent++;
        @(negedge clk);
    endtask

    task automatic pause_sender(int n);
        in_valid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    function automatic logic signed [15:0] unit_part();
        return 16'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    task automatic send_unit_quat();
        real a, b, c, d, n;
        a = $itor(unit_part());
        b = $itor(unit_part());
        c = $itor(unit_part());
        d = $itor(unit_part());
        n = $sqrt(a * a + b * b + c * c + d * d);
        if (n < 1.0)
            send_quat(16384, 0, 0, 0);
        else
            send_quat(16'($rtoi(a * 16384.0 / n)), 16'($rtoi(b * 16384.0 / n)),
                      16'($rtoi(c * 16384.0 / n)), 16'($rtoi(d * 16384.0 / n)));
    endtask

    initial
    begin
        int burst;
        int kind;
        angle_board = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        quat_w = '0;
        quat_x = '0;
        quat_y = '0;
        quat_z = '0;
        quats_sent = 0;
        sending_done = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        // identity, axis turns, gimbal lock, zero, field extremes
        send_quat(16384, 0, 0, 0);
        send_quat(0, 16384, 0, 0);
        send_quat(0, 0, 16384, 0);
        send_quat(0, 0, 0, 16384);
        send_quat(11585, 0, 11585, 0);
        send_quat(11585, 0, -11585, 0);
        send_quat(16384, 0, 16384, 0);
        send_quat(16384, 0, -16384, 0);
        send_quat(0, 0, 0, 0);
        send_quat(-32768, -32768, -32768, -32768);
        send_quat(32767, 32767, 32767, 32767);
        send_quat(32767, -32768, 32767, -32768);
        send_quat(-32768, 32767, -32768, 32767);
        send_quat(-16384, 0, 0, 0);
        send_quat(0, -16384, 0, 0);
        send_quat(8192, 8192, 8192, 8192);
        send_quat(-1, -1, -1, -1);
        send_quat(1, 1, 1, 1);
        send_quat(-11585, 11585, 0, 0);
        send_quat(11585, 0, 0, -11585);
        // random bursts: mostly unit quaternions, some raw full-range noise
        while (quats_sent < 1820)
        begin
            burst = $urandom_range(1, 40);
            repeat (burst)
            begin
                kind = $urandom_range(0, 9);
                if (kind < 7)
                    send_unit_quat();
                else
                    send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
            end
            if ($urandom_range(0, 3) != 0)
                pause_sender($urandom_range(1, 12));
        end
        in_valid <= 1'b0;
        sending_done = 1'b1;
    end

    // receiver stall pattern with one long hold-off
    initial
    begin
        int mode;
        out_stall = 1'b0;
        @(posedge rst_n);
        repeat (300) @(negedge clk);
        out_stall <= 1'b1;
        repeat (200) @(negedge clk);
        forever
        begin
            mode = $urandom_range(0, 2);
            repeat ($urandom_range(10, 60))
            begin
                @(negedge clk);
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    default: out_stall <= ($urandom_range(0, 1) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            angle_board.check_angles(roll_angle, pitch_angle, yaw_angle);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 200000)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        wait (sending_done);
        while (angle_board.pending() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        $display("covered %0d quaternions incl. gimbal lock, zero and full-scale inputs,",
                 quats_sent);
        $display("%0d results checked under random gaps, stalls and a long hold-off",
                 angle_board.checked);
        if (angle_board.errors == 0 && angle_board.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

`default_nettype wire

// ----- files.f -----
sv/q2e_pkg.sv
sv/q2e_cordic.sv
sv/quaternion_to_euler.sv
tb/sv/tb_top.sv
